// File: rtl/core/paged_monochrome_frame_buffer_macros.svh
// Assertion macros used by the checker file.
`ifndef PAGED_MONOCHROME_FRAME_BUFFER_MACROS_SVH
`define PAGED_MONOCHROME_FRAME_BUFFER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PMFB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pmfb check failed");

// Consequent must hold in the cycle after the antecedent.
`define PMFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pmfb check failed");

`endif

// File: rtl/core/pmfb_pkg.sv
`default_nettype none
package pmfb_pkg;

    localparam int COLUMNS   = 128;
    localparam int PAGES     = 8;
    localparam int BUF_BYTES = PAGES * COLUMNS;
    localparam int MEM_DEPTH = 2 * BUF_BYTES;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam int KIND_W = 3;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int PIX_W  = 8;
    localparam int SPAN_W = 7;
    localparam int BYTE_W = 8;

    localparam int CMD_BYTES = 3;
    localparam int SPOS_W    = $clog2(COLUMNS + CMD_BYTES);
    localparam int SPG_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int PC_W      = ($clog2(PAGES + 1) > 4) ? $clog2(PAGES + 1) : 4;
    localparam int COLX_W    = (SPOS_W > COL_W) ? SPOS_W : COL_W;
    localparam int FLIP_W    = PC_W + 4;

    localparam logic [BYTE_W-1:0] PANEL_PAGE_CMD = 8'hB0;
    localparam logic [BYTE_W-1:0] PANEL_COL_HI   = 8'h10;
    localparam logic [BYTE_W-1:0] PANEL_COL_LO   = 8'h00;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 3'd0,
        KIND_WRITE = 3'd1,
        KIND_SET   = 3'd2,
        KIND_FLIP  = 3'd3,
        KIND_SWAP  = 3'd4,
        KIND_SCAN  = 3'd5
    } t_kind;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_CLEAR,
        S_RD_A,
        S_WR_A,
        S_RD_B,
        S_WR_B,
        S_RD_F,
        S_WR_F,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        TGT_FIRST,
        TGT_SECOND,
        TGT_FLIP,
        TGT_SCAN
    } t_tgt;

    typedef struct packed {
        logic load;
        logic sweep_all;
        logic sweep_step;
        logic rd;
        logic wr;
        t_tgt tgt;
        logic page_step;
        logic swap;
        logic emit_cmd;
        logic emit_data;
    } t_dp_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              col_ok;
        logic              bits_zero;
        logic              flip_last;
        logic              sweep_last_all;
        logic              sweep_last_buf;
        logic              scan_is_cmd;
    } t_dp_sts;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic b,
                                                   input logic [PC_W-1:0] pg,
                                                   input logic [COLX_W-1:0] c);
        logic [31:0] t;
        t = 32'(b) * 32'(BUF_BYTES) + 32'(pg) * 32'(COLUMNS) + 32'(c);
        return t[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/pmfb_datapath.sv
`default_nettype none
module pmfb_datapath
    import pmfb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic [COL_W-1:0]  i_col,
    input  wire logic [ROW_W-1:0]  i_row,
    input  wire logic [PIX_W-1:0]  i_pixels,
    input  wire logic [SPAN_W-1:0] i_span,
    output t_dp_sts                o_sts,
    output logic                   o_valid,
    output logic [BYTE_W-1:0]      o_panel_byte,
    output logic                   o_is_command,
    output logic                   o_page_done
);

    logic [BYTE_W-1:0] r_mem [MEM_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    logic [KIND_W-1:0] r_kind;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [PIX_W-1:0]  r_pixels;
    logic [SPAN_W-1:0] r_span;
    logic [PC_W-1:0]   r_page;

    logic              r_draw_sel;
    logic [SPG_W-1:0]  r_scan_page;
    logic [SPOS_W-1:0] r_scan_pos;
    logic [ADDR_W-1:0] r_sweep;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_cmd;
    logic              r_done;

    logic [2:0]        w_bits;
    logic [PC_W-1:0]   w_first_pg;
    logic [PC_W-1:0]   w_pg;
    logic [COLX_W-1:0] w_c;
    logic              w_b;
    logic              w_page_ok;
    logic [ADDR_W-1:0] w_addr;
    logic [BYTE_W-1:0] w_wdata;
    logic              w_we;
    logic [BYTE_W-1:0] w_mask;
    logic [FLIP_W-1:0] w_lo;
    logic [FLIP_W-1:0] w_end;
    logic [FLIP_W-1:0] w_top;
    logic [3:0]        w_hi_sh;
    logic              w_scan_done;
    logic [BYTE_W-1:0] w_cmd_byte;

    assign w_bits     = r_row[2:0];
    assign w_first_pg = PC_W'(r_row[ROW_W-1:3]);
    assign w_hi_sh    = 4'd8 - {1'b0, w_bits};
    assign w_end      = FLIP_W'(r_row) + FLIP_W'(r_span);
    assign w_top      = FLIP_W'(r_row);
    assign w_lo       = FLIP_W'({r_page, 3'b000});

    always_comb begin
        w_mask = '0;
        for (int i = 0; i < 8; i++) begin
            w_mask[i] = ((w_lo + FLIP_W'(i)) >= w_top) && ((w_lo + FLIP_W'(i)) < w_end);
        end
    end

    always_comb begin
        w_b = r_draw_sel;
        w_c = COLX_W'(r_col);
        case (i_cmd.tgt)
            TGT_FIRST:  w_pg = w_first_pg;
            TGT_SECOND: w_pg = w_first_pg + PC_W'(1);
            TGT_FLIP:   w_pg = r_page;
            TGT_SCAN: begin
                w_pg = PC_W'(r_scan_page);
                w_b  = ~r_draw_sel;
                w_c  = COLX_W'(r_scan_pos - SPOS_W'(CMD_BYTES));
            end
            default:    w_pg = r_page;
        endcase
    end

    assign w_page_ok = 32'(w_pg) < 32'(PAGES);

    always_comb begin
        case (i_cmd.tgt)
            TGT_FIRST: begin
                if (r_kind == KIND_SET) begin
                    w_wdata = r_rdata | (8'd1 << w_bits);
                end else begin
                    w_wdata = (r_rdata & 8'((9'd1 << w_bits) - 9'd1))
                            | 8'({8'd0, r_pixels} << w_bits);
                end
            end
            TGT_SECOND: w_wdata = (r_rdata & 8'(8'hFF << w_bits)) | (r_pixels >> w_hi_sh);
            TGT_FLIP:   w_wdata = r_rdata ^ w_mask;
            default:    w_wdata = r_rdata;
        endcase
        if (i_cmd.sweep_step) begin
            w_wdata = '0;
        end
    end

    always_comb begin
        if (i_cmd.sweep_step) begin
            if (i_cmd.sweep_all) begin
                w_addr = r_sweep;
            end else begin
                w_addr = (r_draw_sel ? ADDR_W'(BUF_BYTES) : '0) + r_sweep;
            end
        end else begin
            w_addr = mem_addr(w_b, w_pg, w_c);
        end
    end

    assign w_we = i_cmd.sweep_step || (i_cmd.wr && w_page_ok);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_col    <= i_col;
            r_row    <= i_row;
            r_pixels <= i_pixels;
            r_span   <= i_span;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= PC_W'(i_row[ROW_W-1:3]);
        end else if (i_cmd.page_step) begin
            r_page <= r_page + PC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep_step) begin
            if ((i_cmd.sweep_all && o_sts.sweep_last_all)
                || (!i_cmd.sweep_all && o_sts.sweep_last_buf)) begin
                r_sweep <= '0;
            end else begin
                r_sweep <= r_sweep + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_sel <= 1'b0;
        end else if (i_cmd.swap) begin
            r_draw_sel <= ~r_draw_sel;
        end
    end

    assign w_scan_done = r_scan_pos == SPOS_W'(COLUMNS + CMD_BYTES - 1);

    always_comb begin
        case (r_scan_pos)
            SPOS_W'(0): w_cmd_byte = PANEL_PAGE_CMD | BYTE_W'(r_scan_page);
            SPOS_W'(1): w_cmd_byte = PANEL_COL_HI;
            default:    w_cmd_byte = PANEL_COL_LO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_page <= '0;
            r_scan_pos  <= '0;
        end else if (i_cmd.emit_cmd || i_cmd.emit_data) begin
            if (i_cmd.emit_data && w_scan_done) begin
                r_scan_pos <= '0;
                if (32'(r_scan_page) >= 32'(PAGES - 1)) begin
                    r_scan_page <= '0;
                end else begin
                    r_scan_page <= r_scan_page + SPG_W'(1);
                end
            end else begin
                r_scan_pos <= r_scan_pos + SPOS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_cmd || i_cmd.emit_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_cmd) begin
            r_byte <= w_cmd_byte;
            r_cmd  <= 1'b1;
            r_done <= 1'b0;
        end else if (i_cmd.emit_data) begin
            r_byte <= r_rdata;
            r_cmd  <= 1'b0;
            r_done <= w_scan_done;
        end
    end

    assign o_sts.kind           = r_kind;
    assign o_sts.col_ok         = 32'(r_col) < 32'(COLUMNS);
    assign o_sts.bits_zero      = w_bits == 3'd0;
    assign o_sts.flip_last      = 32'(r_page) >= 32'(PAGES - 1);
    assign o_sts.sweep_last_all = r_sweep == ADDR_W'(MEM_DEPTH - 1);
    assign o_sts.sweep_last_buf = r_sweep == ADDR_W'(BUF_BYTES - 1);
    assign o_sts.scan_is_cmd    = r_scan_pos < SPOS_W'(CMD_BYTES);

    assign o_valid      = r_valid;
    assign o_panel_byte = r_byte;
    assign o_is_command = r_cmd;
    assign o_page_done  = r_done;

endmodule
`default_nettype wire

// File: rtl/core/pmfb_ctrl.sv
`default_nettype none
module pmfb_ctrl
    import pmfb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_sts.sweep_last_all) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_sts.kind)
                    KIND_CLEAR: n_state = S_CLEAR;
                    KIND_WRITE,
                    KIND_SET:   n_state = i_sts.col_ok ? S_RD_A : S_IDLE;
                    KIND_FLIP:  n_state = i_sts.col_ok ? S_RD_F : S_IDLE;
                    KIND_SCAN:  n_state = i_sts.scan_is_cmd ? S_IDLE : S_EMIT;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_CLEAR: begin
                if (i_sts.sweep_last_buf) n_state = S_IDLE;
            end
            S_RD_A: n_state = S_WR_A;
            S_WR_A: begin
                if (i_sts.kind == KIND_WRITE && !i_sts.bits_zero) begin
                    n_state = S_RD_B;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RD_B: n_state = S_WR_B;
            S_WR_B: n_state = S_IDLE;
            S_RD_F: n_state = S_WR_F;
            S_WR_F: n_state = i_sts.flip_last ? S_IDLE : S_RD_F;
            S_EMIT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = r_state != S_IDLE;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep_all  = 1'b1;
                o_cmd.sweep_step = 1'b1;
            end
            S_IDLE: begin
                o_cmd.load = i_start;
            end
            S_DISPATCH: begin
                case (i_sts.kind)
                    KIND_SWAP: o_cmd.swap = 1'b1;
                    KIND_SCAN: begin
                        o_cmd.tgt      = TGT_SCAN;
                        o_cmd.emit_cmd = i_sts.scan_is_cmd;
                        o_cmd.rd       = !i_sts.scan_is_cmd;
                    end
                    default: o_cmd.swap = 1'b0;
                endcase
            end
            S_CLEAR: begin
                o_cmd.sweep_step = 1'b1;
            end
            S_RD_A: begin
                o_cmd.tgt = TGT_FIRST;
                o_cmd.rd  = 1'b1;
            end
            S_WR_A: begin
                o_cmd.tgt = TGT_FIRST;
                o_cmd.wr  = 1'b1;
            end
            S_RD_B: begin
                o_cmd.tgt = TGT_SECOND;
                o_cmd.rd  = 1'b1;
            end
            S_WR_B: begin
                o_cmd.tgt = TGT_SECOND;
                o_cmd.wr  = 1'b1;
            end
            S_RD_F: begin
                o_cmd.tgt = TGT_FLIP;
                o_cmd.rd  = 1'b1;
            end
            S_WR_F: begin
                o_cmd.tgt       = TGT_FLIP;
                o_cmd.wr        = 1'b1;
                o_cmd.page_step = !i_sts.flip_last;
            end
            S_EMIT: begin
                o_cmd.tgt       = TGT_SCAN;
                o_cmd.emit_data = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/paged_monochrome_frame_buffer.sv
`default_nettype none
// Double-buffered paged monochrome frame buffer with one single-port byte store for
// both buffers. A command is taken when start is high and busy is low; the result of
// a scan tick shows on the o_ ports for one cycle with o_valid and cannot be held off.
// Items run through the single memory port, one read or one write a cycle: set dot
// reads and writes one byte, write byte one byte (row on a page boundary) or two,
// flip span each page from page row/8 to the last, and a scan tick for a data byte
// reads one byte; clear zeroes the PAGES*COLUMNS bytes of the draw buffer. After reset
// busy stays high during a pass that zeroes all 2*PAGES*COLUMNS bytes of the store.
module paged_monochrome_frame_buffer
    import pmfb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic [COL_W-1:0]  i_col,
    input  wire logic [ROW_W-1:0]  i_row,
    input  wire logic [PIX_W-1:0]  i_pixels,
    input  wire logic [SPAN_W-1:0] i_span,
    output logic                   o_valid,
    output logic [BYTE_W-1:0]      o_panel_byte,
    output logic                   o_is_command,
    output logic                   o_page_done
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    pmfb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    pmfb_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_kind       (i_kind),
        .i_col        (i_col),
        .i_row        (i_row),
        .i_pixels     (i_pixels),
        .i_span       (i_span),
        .o_sts        (w_sts),
        .o_valid      (o_valid),
        .o_panel_byte (o_panel_byte),
        .o_is_command (o_is_command),
        .o_page_done  (o_page_done)
    );

endmodule
`default_nettype wire

// File: rtl/core/pmfb_checker.sv
`default_nettype none
`include "paged_monochrome_frame_buffer_macros.svh"
module pmfb_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid,
    input wire logic o_is_command,
    input wire logic o_page_done
);

    `PMFB_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)
    `PMFB_ASSERT_NOW(a_idle_on_result, i_clk, i_rst_n, o_valid, !busy)
    `PMFB_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, start && !busy, busy)
    `PMFB_ASSERT_NOW(a_done_on_data, i_clk, i_rst_n, o_valid && o_page_done, !o_is_command)

endmodule

bind paged_monochrome_frame_buffer pmfb_checker u_pmfb_checker (.*);
`default_nettype wire

// File: tb/sv/tb_paged_monochrome_frame_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_paged_monochrome_frame_buffer;
    import pmfb_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    localparam int DIR_ROWS     = 24;
    localparam int RANDOM_ITEMS = 1026;
    localparam int DRAIN_CYCLES = 1100;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              cmd;
        logic              done;
    } t_panel_xfer;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [PIX_W-1:0]  pix;
        logic [SPAN_W-1:0] span;
        logic              pinned;
        t_panel_xfer       want;
    } t_dir_row;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              start    = 1'b0;
    logic              busy;
    logic [KIND_W-1:0] i_kind   = '0;
    logic [COL_W-1:0]  i_col    = '0;
    logic [ROW_W-1:0]  i_row    = '0;
    logic [PIX_W-1:0]  i_pixels = '0;
    logic [SPAN_W-1:0] i_span   = '0;
    logic              o_valid;
    logic [BYTE_W-1:0] o_panel_byte;
    logic              o_is_command;
    logic              o_page_done;

    logic              pin_on   = 1'b0;
    t_panel_xfer       pin_xfer = '0;

    logic [BYTE_W-1:0] frame_shadow [0:MEM_DEPTH-1];
    int                draw_sel;
    int                scan_pg;
    int                scan_ps;
    t_panel_xfer       panel_bytes_due [$];
    int                err_count = 0;
    t_dir_row          dir_table [0:DIR_ROWS-1];

    paged_monochrome_frame_buffer DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_col        (i_col),
        .i_row        (i_row),
        .i_pixels     (i_pixels),
        .i_span       (i_span),
        .o_valid      (o_valid),
        .o_panel_byte (o_panel_byte),
        .o_is_command (o_is_command),
        .o_page_done  (o_page_done)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #50_000_000;
        $display("tb_paged_monochrome_frame_buffer: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic put_byte(input int page, input int col, input logic [7:0] keep,
                            input logic [7:0] set_bits);
        int idx;
        if (page >= PAGES || col >= COLUMNS) begin
            return;
        end
        idx = draw_sel * BUF_BYTES + page * COLUMNS + col;
        frame_shadow[idx] = (frame_shadow[idx] & keep) | set_bits;
    endtask

    task automatic apply_frame_op(input logic [KIND_W-1:0] kind, input logic [COL_W-1:0] col,
                                  input logic [ROW_W-1:0] row, input logic [PIX_W-1:0] pix,
                                  input logic [SPAN_W-1:0] span, output logic emits,
                                  output t_panel_xfer xfer);
        int        page;
        int        bits;
        int        last;
        int        c;
        int        p;
        int        i;
        int        idx;
        logic [7:0] m;
        emits = 1'b0;
        xfer  = '0;
        page  = int'(row[5:3]);
        bits  = int'(row[2:0]);
        case (kind)
            KIND_CLEAR: begin
                for (i = 0; i < BUF_BYTES; i++) begin
                    frame_shadow[draw_sel * BUF_BYTES + i] = 8'h00;
                end
            end
            KIND_WRITE: begin
                put_byte(page, int'(col), (bits == 0) ? 8'h00 : 8'(8'hFF >> (8 - bits)),
                         8'(pix << bits));
                if (bits != 0) begin
                    put_byte(page + 1, int'(col), 8'(8'hFF << bits), 8'(pix >> (8 - bits)));
                end
            end
            KIND_SET: begin
                put_byte(page, int'(col), 8'hFF, 8'(8'h01 << bits));
            end
            KIND_FLIP: begin
                last = int'(row) + int'(span);
                for (p = 0; p < PAGES; p++) begin
                    m = 8'h00;
                    for (i = 0; i < 8; i++) begin
                        if (p * 8 + i >= int'(row) && p * 8 + i < last) begin
                            m[i] = 1'b1;
                        end
                    end
                    if (m != 8'h00 && int'(col) < COLUMNS) begin
                        idx = draw_sel * BUF_BYTES + p * COLUMNS + int'(col);
                        frame_shadow[idx] = frame_shadow[idx] ^ m;
                    end
                end
            end
            KIND_SWAP: begin
                draw_sel = draw_sel ^ 1;
            end
            KIND_SCAN: begin
                if (scan_pg >= PAGES) begin
                    scan_pg = 0;
                end
                emits = 1'b1;
                if (scan_ps < CMD_BYTES) begin
                    xfer.cmd = 1'b1;
                    if (scan_ps == 0) begin
                        xfer.data = PANEL_PAGE_CMD | 8'(scan_pg);
                    end else if (scan_ps == 1) begin
                        xfer.data = PANEL_COL_HI;
                    end else begin
                        xfer.data = PANEL_COL_LO;
                    end
                end else begin
                    c = scan_ps - CMD_BYTES;
                    xfer.data = frame_shadow[(draw_sel ^ 1) * BUF_BYTES + scan_pg * COLUMNS + c];
                    xfer.done = (c + 1 >= COLUMNS);
                end
                if (xfer.done) begin
                    scan_ps = 0;
                    scan_pg++;
                    if (scan_pg >= PAGES) begin
                        scan_pg = 0;
                    end
                end else begin
                    scan_ps++;
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_panel_xfer want;
        t_panel_xfer calc;
        logic        emits;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (panel_bytes_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected panel byte %h", o_panel_byte));
                end else begin
                    want = panel_bytes_due.pop_front();
                    if (o_panel_byte !== want.data) begin
                        report_mismatch($sformatf("panel_byte got %h want %h",
                                                  o_panel_byte, want.data));
                    end
                    if (o_is_command !== want.cmd) begin
                        report_mismatch($sformatf("is_command got %b want %b",
                                                  o_is_command, want.cmd));
                    end
                    if (o_page_done !== want.done) begin
                        report_mismatch($sformatf("page_done got %b want %b",
                                                  o_page_done, want.done));
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                apply_frame_op(i_kind, i_col, i_row, i_pixels, i_span, emits, calc);
                if (emits) begin
                    panel_bytes_due.push_back(pin_on ? pin_xfer : calc);
                end
            end
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [COL_W-1:0] col,
                             input logic [ROW_W-1:0] row, input logic [PIX_W-1:0] pix,
                             input logic [SPAN_W-1:0] span, input logic pinned,
                             input t_panel_xfer want, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start    <= 1'b0;
            i_kind   <= KIND_W'($urandom_range(7));
            i_col    <= COL_W'($urandom_range(127));
            i_row    <= ROW_W'($urandom_range(63));
            i_pixels <= PIX_W'($urandom_range(255));
            i_span   <= SPAN_W'($urandom_range(127));
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_kind   <= kind;
        i_col    <= col;
        i_row    <= row;
        i_pixels <= pix;
        i_span   <= span;
        pin_on   <= pinned;
        pin_xfer <= want;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
    endtask

    initial begin : stimulus
        int                k;
        int                sel;
        int                pct;
        int                counted;
        logic [KIND_W-1:0] kind;
        logic [SPAN_W-1:0] span;
        for (k = 0; k < MEM_DEPTH; k++) begin
            frame_shadow[k] = 8'h00;
        end
        draw_sel = 0;
        scan_pg  = 0;
        scan_ps  = 0;
        dir_table = '{
            '{KIND_SCAN,     7'd0,   6'd0,  8'h00, 7'd0,   1'b1, '{PANEL_PAGE_CMD, 1'b1, 1'b0}},
            '{KIND_SCAN,     7'd0,   6'd0,  8'h00, 7'd0,   1'b1, '{PANEL_COL_HI, 1'b1, 1'b0}},
            '{KIND_SCAN,     7'd0,   6'd0,  8'h00, 7'd0,   1'b1, '{PANEL_COL_LO, 1'b1, 1'b0}},
            '{KIND_SCAN,     7'd0,   6'd0,  8'h00, 7'd0,   1'b1, '{8'h00, 1'b0, 1'b0}},
            '{KIND_WRITE,    7'd0,   6'd0,  8'hFF, 7'd0,   1'b0, '0},
            '{KIND_WRITE,    7'd127, 6'd63, 8'hA5, 7'd0,   1'b0, '0},
            '{KIND_WRITE,    7'd10,  6'd13, 8'h3C, 7'd0,   1'b0, '0},
            '{KIND_WRITE,    7'd1,   6'd7,  8'h00, 7'd0,   1'b0, '0},
            '{KIND_SET,      7'd127, 6'd63, 8'h00, 7'd0,   1'b0, '0},
            '{KIND_SET,      7'd1,   6'd0,  8'h00, 7'd0,   1'b0, '0},
            '{KIND_FLIP,     7'd3,   6'd0,  8'h00, 7'd64,  1'b0, '0},
            '{KIND_FLIP,     7'd2,   6'd60, 8'h00, 7'd127, 1'b0, '0},
            '{KIND_FLIP,     7'd6,   6'd10, 8'hFF, 7'd0,   1'b0, '0},
            '{KIND_SPARE_LO, 7'd127, 6'd63, 8'hFF, 7'd127, 1'b0, '0},
            '{KIND_SPARE_HI, 7'd0,   6'd0,  8'h00, 7'd0,   1'b0, '0},
            '{KIND_SWAP,     7'd0,   6'd0,  8'h00, 7'd0,   1'b0, '0},
            '{KIND_SCAN,     7'd0,   6'd0,  8'h00, 7'd0,   1'b0, '0},
            '{KIND_SCAN,     7'd0,   6'd0,  8'h00, 7'd0,   1'b0, '0},
            '{KIND_SCAN,     7'd0,   6'd0,  8'h00, 7'd0,   1'b0, '0},
            '{KIND_CLEAR,    7'd0,   6'd0,  8'h00, 7'd0,   1'b0, '0},
            '{KIND_SWAP,     7'd0,   6'd0,  8'h00, 7'd0,   1'b0, '0},
            '{KIND_SCAN,     7'd0,   6'd0,  8'h00, 7'd0,   1'b0, '0},
            '{KIND_CLEAR,    7'd0,   6'd0,  8'h00, 7'd0,   1'b0, '0},
            '{KIND_SCAN,     7'd0,   6'd0,  8'h00, 7'd0,   1'b0, '0}
        };
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++) begin
            send_item(dir_table[k].kind, dir_table[k].col, dir_table[k].row,
                      dir_table[k].pix, dir_table[k].span, dir_table[k].pinned,
                      dir_table[k].want, 28);
        end

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pct = (counted < 350) ? 28 : ((counted < 700) ? 54 : 0);
            sel = $urandom_range(99);
            if (sel < 45) begin
                kind = KIND_SCAN;
            end else if (sel < 60) begin
                kind = KIND_WRITE;
            end else if (sel < 72) begin
                kind = KIND_SET;
            end else if (sel < 84) begin
                kind = KIND_FLIP;
            end else if (sel < 90) begin
                kind = KIND_SWAP;
            end else if (sel < 92) begin
                kind = KIND_CLEAR;
            end else if (sel < 95) begin
                kind = ($urandom_range(1) == 0) ? KIND_SPARE_LO : KIND_SPARE_HI;
            end else begin
                kind = KIND_SCAN;
            end
            span = ($urandom_range(3) == 0) ? SPAN_W'($urandom_range(127))
                                            : SPAN_W'($urandom_range(64));
            send_item(kind, COL_W'($urandom_range(127)), ROW_W'($urandom_range(63)),
                      PIX_W'($urandom_range(255)), span, 1'b0, '0, pct);
            counted++;
        end
        start <= 1'b0;

        while (panel_bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_paged_monochrome_frame_buffer: PASS");
        end else begin
            $display("tb_paged_monochrome_frame_buffer: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: files.f
+incdir+rtl/core
rtl/core/pmfb_pkg.sv
rtl/core/pmfb_datapath.sv
rtl/core/pmfb_ctrl.sv
rtl/core/paged_monochrome_frame_buffer.sv
rtl/core/pmfb_checker.sv
tb/sv/tb_paged_monochrome_frame_buffer.sv
